// ===== rtl/core/smta_pkg.sv =====
// Package for the sliding median threshold alert block.
// Holds the payload structs, the sequencer state type, the histogram port struct and constants.
// No dependencies.
`timescale 1ns / 1ps

package smta_pkg;

   localparam int VALUE_BITS = 8;
   localparam int NUM_BINS   = 1 << VALUE_BITS;
   localparam int LEN_W      = 11;
   localparam int CNT_W      = LEN_W;
   localparam int CUM_W      = LEN_W + 1;
   localparam int TOTAL_W    = 32;

   localparam logic [LEN_W-1:0] WINDOW_LENGTH_RESET = LEN_W'(5);

   typedef struct packed {
      logic [VALUE_BITS-1:0] sample;
      logic                  last_sample;
   } req_type;

   typedef struct packed {
      logic               alert;
      logic               window_full;
      logic [TOTAL_W-1:0] alert_total;
      logic               is_last;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN_START,
      ST_SCAN,
      ST_DEC_RD,
      ST_DEC_WR,
      ST_INC_RD,
      ST_INC_WR,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic                  clear;
      logic [VALUE_BITS-1:0] rd_addr;
      logic                  wr_en;
      logic [VALUE_BITS-1:0] wr_addr;
      logic [CNT_W-1:0]      wr_data;
   } hist_req_type;

endpackage

// ===== rtl/core/smta_chan_if.sv =====
// Valid/ready stream channel used for the request and response sides.
// Payload type is set per instance; depends on nothing.
`timescale 1ns / 1ps

interface smta_chan_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/core/smta_hist_mem.sv =====
// Value histogram: one synchronous RAM of bin counts plus one valid flop per bin.
// A clear drops all valid bits at once; an invalid bin reads as zero. Uses smta_pkg.
`timescale 1ns / 1ps

module smta_hist_mem (
   input  logic                                clock,
   input  logic                                reset,
   input  smta_pkg::hist_req_type              hist_req,
   output logic [smta_pkg::CNT_W-1:0]          rd_data
);
   import smta_pkg::*;

   logic [CNT_W-1:0]    mem [NUM_BINS];
   logic [NUM_BINS-1:0] valid_ff;
   logic [CNT_W-1:0]    mem_q_ff;
   logic                vld_q_ff;

   always_ff @(posedge clock) begin
      if (hist_req.wr_en) begin
         mem[hist_req.wr_addr] <= hist_req.wr_data;
      end
      mem_q_ff <= mem[hist_req.rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset || hist_req.clear) begin
         valid_ff <= '0;
         vld_q_ff <= 1'b0;
      end else begin
         if (hist_req.wr_en) begin
            valid_ff[hist_req.wr_addr] <= 1'b1;
         end
         vld_q_ff <= valid_ff[hist_req.rd_addr];
      end
   end

   assign rd_data = vld_q_ff ? mem_q_ff : '0;

endmodule

// ===== rtl/core/sliding_median_threshold_alert.sv =====
// Sliding median threshold alert: one result per sample, alert when sample >= 2 x window median.
// Alerts are raised only once the window is full. While it fills, each sample goes straight to the
// histogram update; once full, the histogram RAM is first scanned for the median, one bin per cycle
// up to all 256 bins, then updated. A new sample waits until the last reaches the response register;
// the next one is taken while that response waits. Reset (synchronous): window length 5, histogram and
// counters cleared; delay line undefined. Depends on smta_pkg, smta_chan_if and smta_hist_mem.
`timescale 1ns / 1ps

module sliding_median_threshold_alert #(
   parameter int WINDOW_MAX = 1024
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_wr_en,
   input  logic [smta_pkg::LEN_W-1:0]   csr_wr_data,
   smta_chan_if.sink                    req_chan,
   smta_chan_if.source                  rsp_chan
);
   import smta_pkg::*;

   localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

   state_type state_ff, state_in;

   logic [LEN_W-1:0]      wl_ff;
   logic [LEN_W-1:0]      eff_len;
   logic [LEN_W-1:0]      len_ff;
   logic [LEN_W-1:0]      fill_ff;
   logic [LEN_W-1:0]      oldest_ff;
   logic [LEN_W-1:0]      ptr_ff;
   logic [LEN_W-1:0]      ptr_sel;
   logic [LEN_W:0]        ptr_next;
   logic [TOTAL_W-1:0]    alert_count_ff;
   logic [VALUE_BITS-1:0] s_ff;
   logic                  last_ff;
   logic                  filling_ff;
   logic                  alert_ff;

   logic [CUM_W-1:0]      cum_ff;
   logic [CUM_W-1:0]      cum_sum;
   logic                  got1_ff;
   logic [VALUE_BITS-1:0] bin_ff;
   logic [VALUE_BITS-1:0] m1_ff;
   logic [VALUE_BITS-1:0] m2_ff;
   logic [LEN_W-1:0]      lo_rank;
   logic [LEN_W-1:0]      hi_rank;
   logic                  hit_lo;
   logic                  hit_hi;
   logic                  scan_end;
   logic [VALUE_BITS:0]   twice_med;

   logic [VALUE_BITS-1:0] dly_mem [WINDOW_MAX];
   logic [VALUE_BITS-1:0] dly_rd_ff;
   logic                  dly_rd_en;
   logic                  dly_wr_en;
   logic [AW-1:0]         dly_wr_addr;

   hist_req_type          hist_req;
   logic [CNT_W-1:0]      hist_rd_data;

   rsp_type               rsp_ff;
   logic                  rsp_valid_ff;
   logic                  req_take;
   logic                  out_load;

   smta_hist_mem u_hist (
      .clock    (clock),
      .reset    (reset),
      .hist_req (hist_req),
      .rd_data  (hist_rd_data)
   );

   // Effective window length: zero acts as one, long values saturate.
   always_comb begin
      if (wl_ff == '0) begin
         eff_len = LEN_W'(1);
      end else if (32'(wl_ff) > WINDOW_MAX) begin
         eff_len = LEN_W'(WINDOW_MAX);
      end else begin
         eff_len = wl_ff;
      end
   end

   assign hi_rank = len_ff >> 1;
   assign lo_rank = len_ff[0] ? (len_ff >> 1) : ((len_ff >> 1) - LEN_W'(1));

   assign cum_sum  = cum_ff + CUM_W'(hist_rd_data);
   assign hit_lo   = !got1_ff && (cum_sum > CUM_W'(lo_rank));
   assign hit_hi   = cum_sum > CUM_W'(hi_rank);
   assign scan_end = hit_hi || (bin_ff == '1);

   assign twice_med = len_ff[0] ? ({1'b0, m1_ff} + {1'b0, m1_ff})
                                : ({1'b0, m1_ff} + {1'b0, m2_ff});

   assign ptr_sel  = (oldest_ff < len_ff) ? oldest_ff : '0;
   assign ptr_next = {1'b0, ptr_ff} + (LEN_W+1)'(1);

   assign req_take = req_chan.valid && req_chan.ready;
   assign out_load = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_chan.ready);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               state_in = (fill_ff < eff_len) ? ST_INC_RD : ST_SCAN_START;
            end
         end
         ST_SCAN_START: state_in = ST_SCAN;
         ST_SCAN: begin
            if (scan_end) begin
               state_in = ST_DEC_RD;
            end
         end
         ST_DEC_RD: state_in = ST_DEC_WR;
         ST_DEC_WR: state_in = ST_INC_RD;
         ST_INC_RD: state_in = ST_INC_WR;
         ST_INC_WR: state_in = ST_DONE;
         ST_DONE: begin
            if (out_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Memory controls and handshake.
   always_comb begin
      hist_req         = '0;
      hist_req.clear   = ((state_ff == ST_IDLE) && csr_wr_en) || (out_load && last_ff);
      dly_rd_en        = 1'b0;
      dly_wr_en        = 1'b0;
      dly_wr_addr      = filling_ff ? AW'(fill_ff) : AW'(ptr_ff);
      req_chan.ready   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_chan.ready = !csr_wr_en;
         end
         ST_SCAN_START: begin
            hist_req.rd_addr = '0;
            dly_rd_en        = 1'b1;
         end
         ST_SCAN: begin
            hist_req.rd_addr = bin_ff + VALUE_BITS'(1);
         end
         ST_DEC_RD: begin
            hist_req.rd_addr = dly_rd_ff;
         end
         ST_DEC_WR: begin
            hist_req.wr_en   = 1'b1;
            hist_req.wr_addr = dly_rd_ff;
            hist_req.wr_data = (hist_rd_data != '0) ? (hist_rd_data - CNT_W'(1)) : '0;
         end
         ST_INC_RD: begin
            hist_req.rd_addr = s_ff;
         end
         ST_INC_WR: begin
            hist_req.wr_en   = 1'b1;
            hist_req.wr_addr = s_ff;
            hist_req.wr_data = hist_rd_data + CNT_W'(1);
            dly_wr_en        = 1'b1;
         end
         ST_DONE: begin
         end
         default: begin
         end
      endcase
   end

   // Delay line RAM.
   always_ff @(posedge clock) begin
      if (dly_wr_en) begin
         dly_mem[dly_wr_addr] <= s_ff;
      end
      if (dly_rd_en) begin
         dly_rd_ff <= dly_mem[AW'(ptr_sel)];
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         wl_ff          <= WINDOW_LENGTH_RESET;
         fill_ff        <= '0;
         oldest_ff      <= '0;
         alert_count_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         if ((state_ff == ST_IDLE) && csr_wr_en) begin
            wl_ff          <= csr_wr_data;
            fill_ff        <= '0;
            oldest_ff      <= '0;
            alert_count_ff <= '0;
         end
         if ((state_ff == ST_DEC_RD) && ({1'b0, s_ff} >= twice_med)
             && (alert_count_ff != '1)) begin
            alert_count_ff <= alert_count_ff + TOTAL_W'(1);
         end
         if (state_ff == ST_INC_WR) begin
            if (filling_ff) begin
               fill_ff   <= fill_ff + LEN_W'(1);
               oldest_ff <= '0;
            end else begin
               oldest_ff <= (ptr_next >= {1'b0, len_ff}) ? '0 : ptr_next[LEN_W-1:0];
            end
         end
         if (out_load && last_ff) begin
            fill_ff        <= '0;
            oldest_ff      <= '0;
            alert_count_ff <= '0;
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      if (req_take) begin
         s_ff       <= req_chan.payload.sample;
         last_ff    <= req_chan.payload.last_sample;
         len_ff     <= eff_len;
         filling_ff <= fill_ff < eff_len;
         alert_ff   <= 1'b0;
      end
      case (state_ff)
         ST_SCAN_START: begin
            ptr_ff  <= ptr_sel;
            cum_ff  <= '0;
            got1_ff <= 1'b0;
            bin_ff  <= '0;
            m1_ff   <= '0;
            m2_ff   <= '0;
         end
         ST_SCAN: begin
            cum_ff <= cum_sum;
            bin_ff <= bin_ff + VALUE_BITS'(1);
            if (hit_lo) begin
               m1_ff   <= bin_ff;
               got1_ff <= 1'b1;
            end
            if (hit_hi) begin
               m2_ff <= bin_ff;
            end
         end
         ST_DEC_RD: begin
            alert_ff <= {1'b0, s_ff} >= twice_med;
         end
         default: begin
         end
      endcase
      if (out_load) begin
         rsp_ff.alert       <= alert_ff;
         rsp_ff.window_full <= !filling_ff;
         rsp_ff.alert_total <= alert_count_ff;
         rsp_ff.is_last     <= last_ff;
      end
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_ff;

   // The fill level never passes the window length of the sample in work.
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> (fill_ff <= len_ff))
      else $error("fill level above window length");

   // A full-window update always targets a slot inside the window.
   a_ptr_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DEC_RD) |-> (ptr_ff < len_ff))
      else $error("delay line pointer outside window");

   // The scan never runs past the last bin.
   a_scan_stop: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_SCAN) && (bin_ff == '1)) |=> (state_ff == ST_DEC_RD))
      else $error("histogram scan ran past last bin");

   // A new response only appears out of the final sequencer state.
   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      ($rose(rsp_valid_ff)) |-> ($past(state_ff) == ST_DONE))
      else $error("response raised outside of completion");

   // No histogram write while a histogram clear, from a configuration write or a sequence end, is in progress.
   a_clr_wr: assert property (@(posedge clock) disable iff (reset)
      hist_req.clear |-> !hist_req.wr_en)
      else $error("histogram write during clear");

endmodule

// ===== bench/testbench.sv =====
// Self-checking testbench for sliding_median_threshold_alert: directed and random sample streams,
// a running histogram predictor, and random idling on both channels.
// Depends on smta_pkg, smta_chan_if and the sliding_median_threshold_alert RTL.
`timescale 1ns / 1ps

module testbench;
   import smta_pkg::*;

   localparam int WINDOW_CAP      = 1024;
   localparam int HOLD_OFF_CYCLES = 600;
   localparam int SETTLE_CYCLES   = 300;
   localparam int LONG_RUN        = 250;

   logic             clock;
   logic             reset;
   logic             csr_wr_en;
   logic [LEN_W-1:0] csr_wr_data;

   smta_chan_if #(.payload_type(req_type)) req_chan ();
   smta_chan_if #(.payload_type(rsp_type)) rsp_chan ();

   sliding_median_threshold_alert #(.WINDOW_MAX(WINDOW_CAP)) dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan)
   );

   // Predictor state: histogram, window store and counters of the current sequence.
   int unsigned           bin_count [NUM_BINS];
   logic [VALUE_BITS-1:0] window_store [WINDOW_CAP];
   int unsigned           samples_held;
   int unsigned           oldest_slot;
   logic [TOTAL_W-1:0]    alert_run;
   logic [LEN_W-1:0]      window_len_reg;
   rsp_type               pending_results [$];

   int unsigned error_count   = 0;
   int unsigned sent_count    = 0;
   int unsigned setting_count = 0;
   int unsigned alert_seen    = 0;
   int unsigned full_seen     = 0;

   // Sender and receiver pacing knobs, changed by the tests.
   int unsigned gap_max      = 0;
   int unsigned burst_left   = 0;
   int unsigned ready_mode   = 0;
   int unsigned hold_off_req = 0;

   function automatic void restart_sequence();
      foreach (bin_count[i])
         bin_count[i] = 0;
      samples_held = 0;
      oldest_slot  = 0;
      alert_run    = '0;
   endfunction

   function automatic int unsigned active_length();
      if (window_len_reg == 0)
         return 1;
      if (window_len_reg > WINDOW_CAP)
         return WINDOW_CAP;
      return int'(window_len_reg);
   endfunction

   // Twice the window median: 2*m for odd windows, m1+m2 for even ones.
   function automatic int unsigned median_doubled(int unsigned len);
      int unsigned low_rank;
      int unsigned high_rank;
      int unsigned running;
      int unsigned m1;
      int unsigned m2;
      int unsigned v;
      bit          found_low;
      low_rank  = (len % 2 == 1) ? len / 2 : len / 2 - 1;
      high_rank = len / 2;
      running   = 0;
      m1        = 0;
      m2        = 0;
      found_low = 0;
      for (v = 0; v < NUM_BINS; v++) begin
         running += bin_count[v];
         if (!found_low && running > low_rank) begin
            m1        = v;
            found_low = 1;
         end
         if (running > high_rank) begin
            m2 = v;
            break;
         end
      end
      return (len % 2 == 1) ? m1 + m1 : m1 + m2;
   endfunction

   function automatic rsp_type predict_alert(req_type item);
      rsp_type               result;
      int unsigned           len;
      int unsigned           slot;
      logic [VALUE_BITS-1:0] oldest;
      len            = active_length();
      result         = '0;
      result.is_last = item.last_sample;
      if (samples_held < len) begin
         window_store[samples_held] = item.sample;
         bin_count[item.sample]++;
         samples_held++;
         oldest_slot = 0;
      end else begin
         slot               = (oldest_slot < len) ? oldest_slot : 0;
         oldest             = window_store[slot];
         result.window_full = 1'b1;
         if (item.sample >= median_doubled(len)) begin
            result.alert = 1'b1;
            if (alert_run != '1)
               alert_run++;
         end
         if (bin_count[oldest] > 0)
            bin_count[oldest]--;
         bin_count[item.sample]++;
         window_store[slot] = item.sample;
         slot++;
         oldest_slot = (slot >= len) ? 0 : slot;
      end
      result.alert_total = alert_run;
      if (item.last_sample)
         restart_sequence();
      return result;
   endfunction

   function automatic void check_field(string field, logic [TOTAL_W-1:0] want,
                                       logic [TOTAL_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
         error_count++;
      end
   endfunction

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Receiver: ready follows the current stall pattern, or stays low for a requested hold-off.
   initial begin
      int unsigned stall_left;
      int unsigned phase;
      stall_left    = 0;
      phase         = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_req != 0) begin
            stall_left   = hold_off_req;
            hold_off_req = 0;
         end
         phase = (phase + 1) % 11;
         if (stall_left != 0) begin
            stall_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            case (ready_mode)
               0:       rsp_chan.ready <= 1'b1;
               1:       rsp_chan.ready <= ($urandom_range(0, 3) != 0);
               default: rsp_chan.ready <= (phase > 2);
            endcase
         end
      end
   end

   // Every response transfer is compared with the oldest pending prediction.
   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         got = rsp_chan.payload;
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected response, expected none, actual %h", $time, got);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            check_field("alert", TOTAL_W'(want.alert), TOTAL_W'(got.alert));
            check_field("window_full", TOTAL_W'(want.window_full), TOTAL_W'(got.window_full));
            check_field("alert_total", want.alert_total, got.alert_total);
            check_field("is_last", TOTAL_W'(want.is_last), TOTAL_W'(got.is_last));
            alert_seen += int'(want.alert);
            full_seen  += int'(want.window_full);
         end
      end
   end

   // Offers one sample; valid stays high into the next call unless a gap is due.
   task automatic send_sample(input logic [VALUE_BITS-1:0] value, input logic last);
      int unsigned gap;
      req_type     item;
      gap              = 0;
      item.sample      = value;
      item.last_sample = last;
      if (gap_max != 0) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 8);
            gap        = $urandom_range(1, gap_max);
         end
         burst_left--;
      end
      if (gap != 0) begin
         @(negedge clock);
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end else begin
         @(negedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.payload <= item;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      pending_results.push_back(predict_alert(item));
      sent_count++;
   endtask

   task automatic stop_sending();
      @(negedge clock);
      req_chan.valid <= 1'b0;
   endtask

   task automatic wait_drained();
      while (pending_results.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // The register is only written once the block has gone quiet.
   task automatic write_window(input int unsigned value);
      stop_sending();
      wait_drained();
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= LEN_W'(value);
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      window_len_reg = LEN_W'(value);
      restart_sequence();
      setting_count++;
   endtask

   // Mostly samples near a baseline, some near twice the baseline, a few anywhere.
   function automatic logic [VALUE_BITS-1:0] noisy_sample(int unsigned base);
      int unsigned pick;
      int          value;
      pick = $urandom_range(0, 19);
      if (pick == 0)
         value = $urandom_range(0, NUM_BINS - 1);
      else if (pick < 4)
         value = 2 * base + $urandom_range(0, 8) - 4;
      else
         value = base + $urandom_range(0, 8) - 4;
      if (value < 0)
         value = 0;
      if (value > NUM_BINS - 1)
         value = NUM_BINS - 1;
      return VALUE_BITS'(value);
   endfunction

   task automatic test_default_window();
      gap_max    = 0;
      ready_mode = 0;
      send_sample(8'd0, 1'b0);
      send_sample(8'd255, 1'b0);
      send_sample(8'd0, 1'b0);
      send_sample(8'd0, 1'b0);
      send_sample(8'd0, 1'b0);
      send_sample(8'd0, 1'b0);
      send_sample(8'd255, 1'b0);
      send_sample(8'd1, 1'b0);
      send_sample(8'd254, 1'b1);
   endtask

   task automatic test_single_sample_window();
      write_window(0);
      ready_mode = 2;
      // A sequence that ends on its very first sample.
      send_sample(8'd7, 1'b1);
      send_sample(8'd10, 1'b0);
      send_sample(8'd20, 1'b0);
      send_sample(8'd39, 1'b0);
      send_sample(8'd78, 1'b1);
   endtask

   task automatic test_even_window();
      write_window(2);
      ready_mode = 1;
      send_sample(8'd4, 1'b0);
      send_sample(8'd6, 1'b0);
      send_sample(8'd10, 1'b0);
      send_sample(8'd9, 1'b0);
      send_sample(8'd255, 1'b1);
   endtask

   task automatic test_restart_on_write();
      write_window(3);
      send_sample(8'd200, 1'b0);
      send_sample(8'd200, 1'b0);
      // Writing the register mid-sequence must drop the two large samples.
      write_window(3);
      send_sample(8'd1, 1'b0);
      send_sample(8'd1, 1'b0);
      send_sample(8'd1, 1'b0);
      send_sample(8'd2, 1'b1);
   endtask

   task automatic test_long_window();
      int unsigned i;
      write_window(2047);
      gap_max    = 0;
      ready_mode = 1;
      for (i = 0; i < LONG_RUN; i++)
         send_sample(noisy_sample(30), i == LONG_RUN - 1);
      write_window(WINDOW_CAP);
      for (i = 0; i < 6; i++)
         send_sample(noisy_sample(30), i == 5);
   endtask

   task automatic test_receiver_hold_off();
      int unsigned i;
      write_window(4);
      gap_max    = 0;
      ready_mode = 0;
      for (i = 0; i < 4; i++)
         send_sample(noisy_sample(20), 1'b0);
      hold_off_req = HOLD_OFF_CYCLES;
      repeat (2) @(posedge clock);
      for (i = 0; i < 8; i++)
         send_sample(noisy_sample(20), i == 7);
      stop_sending();
      wait_drained();
   endtask

   task automatic test_random_sequences(input int unsigned budget);
      int unsigned start;
      int unsigned len;
      int unsigned seq_len;
      int unsigned base;
      int unsigned i;
      start = sent_count;
      while (sent_count - start < budget) begin
         case ($urandom_range(0, 9))
            0:       len = $urandom_range(0, 1);
            1:       len = $urandom_range(32, 64);
            default: len = $urandom_range(2, 12);
         endcase
         write_window(len);
         gap_max    = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
         ready_mode = $urandom_range(0, 2);
         repeat ($urandom_range(1, 3)) begin
            seq_len = $urandom_range(1, 3 * len + 12);
            base    = $urandom_range(0, 100);
            // Now and then a sequence runs on without its closing sample.
            for (i = 0; i < seq_len; i++)
               send_sample(noisy_sample(base),
                           (i == seq_len - 1) && ($urandom_range(0, 7) != 0));
         end
      end
   endtask

   initial begin
      reset            = 1'b1;
      csr_wr_en        = 1'b0;
      csr_wr_data      = '0;
      req_chan.valid   = 1'b0;
      req_chan.payload = '0;
      window_len_reg   = WINDOW_LENGTH_RESET;
      restart_sequence();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      repeat (SETTLE_CYCLES) @(posedge clock);

      test_default_window();
      test_single_sample_window();
      test_even_window();
      test_restart_on_write();
      test_long_window();
      test_receiver_hold_off();
      test_random_sequences(220);

      stop_sending();
      wait_drained();
      $display("Run covered %0d samples over %0d window settings: %0d full-window results, %0d alerts.",
               sent_count, setting_count, full_seen, alert_seen);
      $display("A %0d-cycle receiver hold-off and drain pauses were included; %0d mismatches.",
               HOLD_OFF_CYCLES, error_count);
      if (error_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   initial begin
      #50_000_000;
      $display("Timeout: the run did not complete.");
      $display("== FAIL ==");
      $finish;
   end

endmodule
